/* hw/rtl/fie_pkg.sv */
// Shared types and constants for the force index EMA block.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
`default_nettype none

package fie_pkg;

    localparam int DATA_W  = 64;
    localparam int INDEX_W = 16;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Reset values of the configuration registers.
    localparam logic [8:0]  PERIOD_RST = 9'd13;
    localparam logic [31:0] ALPHA_RST  = 32'd613566757;
    localparam logic [7:0]  WARMUP_RST = 8'd0;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_ALPHA  = 2'd1;
    localparam logic [1:0] REG_WARMUP = 2'd2;

    typedef struct packed {
        logic [8:0]  period;
        logic [31:0] alpha;
        logic [7:0]  warmup;
    } fie_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_force;
        logic make_force;
        logic seed_add;
        logic div_start;
        logic div_load;
        logic ema_diff;
        logic mul_lo;
        logic mul_hi;
        logic ema_q;
        logic ema_step;
        logic out_load;
    } fie_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_bar;
        logic raw_mode;
        logic seeding;
        logic seed_end;
        logic emit;
        logic div_busy;
        logic out_free;
    } fie_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/fie_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Used by the datapath to seed the EMA. Depends on fie_pkg.
`default_nettype none

module fie_div
    import fie_pkg::*;
#(
    parameter int DEN_W = 9
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]         divisor,
    output logic                          busy,
    output logic signed [DATA_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DATA_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // The dividend register shifts out at the top while quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DATA_W-1];
            quo_reg <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DEN_W-1:0];
            end
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

/* hw/rtl/fie_ctrl.sv */
// Controller state machine: sequences one bar through the datapath.
// Drives fie_cmd_t commands and reads fie_stat_t status. Depends on fie_pkg.
`default_nettype none

module fie_ctrl
    import fie_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire fie_stat_t stat,
    output fie_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_FORCE   = 4'd2;
    localparam logic [3:0] S_SEED    = 4'd3;
    localparam logic [3:0] S_DIVGO   = 4'd4;
    localparam logic [3:0] S_DIVWAIT = 4'd5;
    localparam logic [3:0] S_DIFF    = 4'd6;
    localparam logic [3:0] S_MLO     = 4'd7;
    localparam logic [3:0] S_MHI     = 4'd8;
    localparam logic [3:0] S_SUMQ    = 4'd9;
    localparam logic [3:0] S_STEP    = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // The first bar of a series only stores its close.
                if (stat.first_bar) begin
                    state_next = S_OUT;
                end else begin
                    cmd.mul_force = 1'b1;
                    state_next    = S_FORCE;
                end
            end
            S_FORCE: begin
                cmd.make_force = 1'b1;
                if (stat.raw_mode) begin
                    state_next = S_OUT;
                end else if (stat.seeding) begin
                    state_next = S_SEED;
                end else begin
                    state_next = S_DIFF;
                end
            end
            S_SEED: begin
                cmd.seed_add = 1'b1;
                state_next   = stat.seed_end ? S_DIVGO : S_OUT;
            end
            S_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (!stat.div_busy) begin
                    cmd.div_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_DIFF: begin
                cmd.ema_diff = 1'b1;
                state_next   = S_MLO;
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUMQ;
            end
            S_SUMQ: begin
                cmd.ema_q  = 1'b1;
                state_next = S_STEP;
            end
            S_STEP: begin
                cmd.ema_step = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (!stat.emit) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/fie_datapath.sv */
// Datapath: bar state, shared 32x32 multiplier, seed accumulator, EMA update
// and the output register. Instantiates fie_div. Depends on fie_pkg.
`default_nettype none

module fie_datapath
    import fie_pkg::*;
#(
    parameter int MAX_PERIOD  = 256,
    parameter int PRICE_BITS  = 24,
    parameter int VOLUME_BITS = 31
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire fie_cfg_t               cfg,
    input  wire fie_cmd_t               cmd,
    output fie_stat_t                   stat,
    input  wire logic [PRICE_BITS-1:0]  close_price,
    input  wire logic [VOLUME_BITS-1:0] bar_volume,
    input  wire logic                   series_start,
    input  wire logic                   last_bar,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic signed [DATA_W-1:0]    m_force_value,
    output logic [INDEX_W-1:0]          m_bar_index,
    output logic                        m_last
);

    localparam int P_W = $clog2(MAX_PERIOD + 1);
    localparam logic signed [DATA_W:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DATA_W:0] SUM_LO = -SUM_HI;

    // Running series state.
    logic [PRICE_BITS-1:0]    prev_close_reg;
    logic [INDEX_W-1:0]       bars_seen_reg;
    logic signed [DATA_W-1:0] seed_reg;
    logic signed [DATA_W-1:0] ema_reg;
    logic                     m_valid_reg;

    // Per-bar working registers.
    logic [INDEX_W-1:0]       b_reg;
    logic                     last_reg;
    logic [PRICE_BITS-1:0]    dmag_reg;
    logic                     dneg_reg;
    logic [VOLUME_BITS-1:0]   vol_reg;
    logic [DATA_W-1:0]        prod_reg;
    logic signed [DATA_W-1:0] force_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [31:0]              p0hi_reg;
    logic                     p0nz_reg;
    logic [DATA_W-1:0]        q_reg;
    logic signed [DATA_W-1:0] out_force_reg;
    logic [INDEX_W-1:0]       out_index_reg;
    logic                     out_last_reg;

    logic [INDEX_W-1:0]       b_new;
    logic [P_W-1:0]           p_eff;
    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [DATA_W-1:0]        mul_p;
    logic signed [DATA_W:0]   seed_sum;
    logic signed [DATA_W-1:0] seed_next;
    logic signed [DATA_W-1:0] div_quot;
    logic                     div_busy;

    assign b_new = series_start ? '0 : bars_seen_reg;

    always_comb begin
        if (cfg.period == '0) begin
            p_eff = P_W'(1);
        end else if (32'(cfg.period) > 32'(MAX_PERIOD)) begin
            p_eff = P_W'(MAX_PERIOD);
        end else begin
            p_eff = P_W'(cfg.period);
        end
    end

    // One multiplier serves the raw force and both halves of the alpha product.
    always_comb begin
        if (cmd.mul_force) begin
            mul_a = 32'(dmag_reg);
            mul_b = 32'(vol_reg);
        end else begin
            mul_a = cmd.mul_hi ? mag_reg[63:32] : mag_reg[31:0];
            mul_b = cfg.alpha;
        end
    end
    assign mul_p = mul_a * mul_b;

    assign seed_sum = {seed_reg[DATA_W-1], seed_reg} + {force_reg[DATA_W-1], force_reg};

    always_comb begin
        if (seed_sum > SUM_HI) begin
            seed_next = SAT_MAX;
        end else if (seed_sum < SUM_LO) begin
            seed_next = -SAT_MAX;
        end else begin
            seed_next = seed_sum[DATA_W-1:0];
        end
    end

    fie_div #(
        .DEN_W (P_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (seed_reg),
        .divisor  (p_eff),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_close_reg <= '0;
            bars_seen_reg  <= '0;
            seed_reg       <= '0;
            ema_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                prev_close_reg <= close_price;
                bars_seen_reg  <= (b_new == '1) ? b_new : b_new + 1'b1;
                if (series_start) begin
                    seed_reg <= '0;
                    ema_reg  <= '0;
                end
            end
            if (cmd.seed_add) begin
                seed_reg <= seed_next;
            end
            if (cmd.div_load) begin
                ema_reg <= div_quot;
            end
            if (cmd.ema_step) begin
                ema_reg <= neg_reg ? ema_reg - $signed(q_reg) : ema_reg + $signed(q_reg);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            b_reg    <= b_new;
            last_reg <= last_bar;
            vol_reg  <= bar_volume;
            dneg_reg <= close_price < prev_close_reg;
            dmag_reg <= (close_price < prev_close_reg) ? prev_close_reg - close_price
                                                       : close_price - prev_close_reg;
        end
        if (cmd.mul_force || cmd.mul_lo || cmd.mul_hi) begin
            prod_reg <= mul_p;
        end
        if (cmd.make_force) begin
            force_reg <= dneg_reg ? -$signed(prod_reg) : $signed(prod_reg);
        end
        if (cmd.ema_diff) begin
            neg_reg <= force_reg < ema_reg;
            mag_reg <= (force_reg < ema_reg) ? DATA_W'(ema_reg - force_reg)
                                             : DATA_W'(force_reg - ema_reg);
        end
        // During the high half multiply the register still holds the low half.
        if (cmd.mul_hi) begin
            p0hi_reg <= prod_reg[63:32];
            p0nz_reg <= |prod_reg[31:0];
        end
        // A negative step is rounded toward minus infinity.
        if (cmd.ema_q) begin
            q_reg <= prod_reg + DATA_W'(p0hi_reg) + DATA_W'(neg_reg & p0nz_reg);
        end
        if (cmd.out_load) begin
            out_force_reg <= stat.raw_mode ? force_reg : ema_reg;
            out_index_reg <= b_reg;
            out_last_reg  <= last_reg;
        end
    end

    always_comb begin
        stat.first_bar = b_reg == '0;
        stat.raw_mode  = p_eff == P_W'(1);
        stat.seeding   = 32'(b_reg) <= 32'(p_eff);
        stat.seed_end  = 32'(b_reg) == 32'(p_eff);
        stat.emit      = 32'(b_reg) >= 32'(p_eff) + 32'(cfg.warmup);
        stat.div_busy  = div_busy;
        stat.out_free  = !m_valid_reg || m_tready;
    end

    assign m_tvalid      = m_valid_reg;
    assign m_force_value = out_force_reg;
    assign m_bar_index   = out_index_reg;
    assign m_last        = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/force_index_ema_top.sv */
// Elder force index with EMA smoothing: configuration registers and stream ports.
// Instantiates fie_ctrl and fie_datapath. Depends on fie_pkg.
//
// Usage: bars enter on the s_ stream, one transfer per bar, and results leave on
// the m_ stream. A bar with series_start (s_tuser) set restarts the series as
// bar index 0. Bar 0 of a series gives no result; later bars give one result
// each from bar index period+warmup_extra on, with m_tlast echoing s_tlast.
// The block works on one bar at a time, and s_tready is high only when idle.
// Each bar's work follows the controller's sequence over the single shared
// 32x32 multiplier, with its own path for bar 0, for period one, while the seed
// sum accumulates, for an EMA update and for the bar that seeds the EMA, where
// the divider produces one quotient bit per cycle. A result appears on m_tvalid
// as the controller returns to idle and sits in an output register, so the next
// bar is taken while it waits. If the receiver holds m_tready low, the block
// stalls only when a second result is due.
// Reset (aresetn low, synchronous) clears the series state, the output valid and
// the registers to period 13, alpha 613566757 and warmup_extra 0.
// Registers must be written by the user over the APB-style port only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module force_index_ema_top
    import fie_pkg::*;
#(
    parameter int  MAX_PERIOD  = 256,
    parameter int  PRICE_BITS  = 24,
    parameter int  VOLUME_BITS = 31,
    localparam int S_TDATA_W   = ((PRICE_BITS + VOLUME_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // APB-style configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Bar input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // close_price, bar_volume, zero pad
    input  wire logic                 s_tlast,
    input  wire logic                 s_tuser,  // series_start
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [79:0]               m_tdata,  // force_value, bar_index
    output logic                      m_tlast
);

    logic [8:0]  period_reg;
    logic [31:0] alpha_reg;
    logic [7:0]  warmup_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    fie_cfg_t                 cfg;
    fie_cmd_t                 cmd;
    fie_stat_t                stat;
    logic signed [DATA_W-1:0] force_value;
    logic [INDEX_W-1:0]       bar_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RST;
            alpha_reg  <= ALPHA_RST;
            warmup_reg <= WARMUP_RST;
        end else if (wr_en) begin
            case (reg_index)
                REG_PERIOD: period_reg <= pwdata[8:0];
                REG_ALPHA:  alpha_reg  <= pwdata;
                REG_WARMUP: warmup_reg <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_PERIOD: prdata = 32'(period_reg);
            REG_ALPHA:  prdata = alpha_reg;
            REG_WARMUP: prdata = 32'(warmup_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.period = period_reg;
    assign cfg.alpha  = alpha_reg;
    assign cfg.warmup = warmup_reg;

    fie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fie_datapath #(
        .MAX_PERIOD  (MAX_PERIOD),
        .PRICE_BITS  (PRICE_BITS),
        .VOLUME_BITS (VOLUME_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .close_price   (s_tdata[PRICE_BITS-1:0]),
        .bar_volume    (s_tdata[PRICE_BITS +: VOLUME_BITS]),
        .series_start  (s_tuser),
        .last_bar      (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_force_value (force_value),
        .m_bar_index   (bar_index),
        .m_last        (m_tlast)
    );

    assign m_tdata = {bar_index, force_value};

endmodule

`default_nettype wire

/* hw/rtl/fie_chk.sv */
// Port-level checker for force_index_ema_top, attached with a bind statement.
// Sees only the top level's stream ports. No package dependency.
`default_nettype none

module fie_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled result must hold still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One bar at a time: after a transfer the input is not ready at once.
    a_one_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transfer");

    // A new result is raised as the controller returns to idle.
    a_rise_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while a bar is in progress");

    // Bar zero never yields a result.
    a_index_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[79:64] != 16'd0)
        else $error("result carries bar index zero");

    // Reset leaves the block idle with no result pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind force_index_ema_top fie_chk u_fie_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/force_index_ema_checker.sv */
`timescale 1ns / 100ps
// Result checker for force_index_ema_top: watches the bar, result and register ports,
// predicts each smoothed force value and compares it with what the block sends.
// Depends on fie_pkg.

module force_index_ema_checker
    import fie_pkg::*;
#(
    parameter int S_TDATA_W  = 56,
    parameter int MAX_PERIOD = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // close_price, bar_volume, zero pad
    input  logic                 s_tlast,
    input  logic                 s_tuser,  // series_start
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [79:0]          m_tdata,  // force_value, bar_index
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);

    typedef struct packed {
        logic signed [63:0] force_value;
        logic [15:0]        bar_index;
        logic               last;
    } bar_result_t;

    bar_result_t due_results[$];

    logic [8:0]  period_q;
    logic [31:0] alpha_q;
    logic [7:0]  warmup_q;
    logic [23:0] prev_close;
    longint      ema_acc;
    longint      seed_acc;
    logic [15:0] bars_seen;
    int          mismatches = 0;
    int          checked = 0;

    task automatic advance_bar(input logic [23:0] close_px, input logic [30:0] volume,
                               input logic start, input logic tail);
        int unsigned        span;
        logic [15:0]        idx;
        longint             force_now;
        logic signed [65:0] wide;
        logic signed [99:0] prod;
        bar_result_t        res;

        span = period_q;
        if (span == 0) begin
            span = 1;
        end else if (span > MAX_PERIOD) begin
            span = MAX_PERIOD;
        end
        if (start) begin
            bars_seen = '0;
            ema_acc   = 0;
            seed_acc  = 0;
        end
        idx = bars_seen;
        if (bars_seen != 16'hFFFF) begin
            bars_seen = bars_seen + 16'd1;
        end
        force_now = 0;
        if (idx != 0) begin
            force_now = (longint'(close_px) - longint'(prev_close)) * longint'(volume);
        end
        prev_close = close_px;
        if (idx == 0) begin
            return;
        end

        if (span > 1) begin
            if (idx <= span) begin
                // The seed sum saturates symmetrically, never at the most negative code.
                wide = seed_acc;
                wide = wide + force_now;
                if (wide > SAT_MAX) begin
                    wide = SAT_MAX;
                end else if (wide < -SAT_MAX) begin
                    wide = -SAT_MAX;
                end
                seed_acc = wide[63:0];
                if (idx == span) begin
                    ema_acc = seed_acc / longint'(span);
                end
            end else begin
                // Exact product, then an arithmetic shift, which rounds towards minus infinity.
                wide    = force_now;
                wide    = wide - ema_acc;
                prod    = wide * $signed({2'b00, alpha_q});
                ema_acc = ema_acc + prod[95:32];
            end
        end

        if (idx >= span + warmup_q) begin
            res.force_value = (span == 1) ? force_now : ema_acc;
            res.bar_index   = idx;
            res.last        = tail;
            due_results.push_back(res);
        end
    endtask

    task automatic check_result(input logic signed [63:0] got_force, input logic [15:0] got_index,
                                input logic got_last);
        bar_result_t want;

        checked++;
        if (due_results.size() == 0) begin
            $error("result with no bar waiting for it: bar_index %0d", got_index);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        if (got_force !== want.force_value) begin
            $error("force_value: expected %0d, got %0d", want.force_value, got_force);
            mismatches++;
        end
        if (got_index !== want.bar_index) begin
            $error("bar_index: expected %0d, got %0d", want.bar_index, got_index);
            mismatches++;
        end
        if (got_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got_last);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            period_q   = PERIOD_RST;
            alpha_q    = ALPHA_RST;
            warmup_q   = WARMUP_RST;
            prev_close = '0;
            ema_acc    = 0;
            seed_acc   = 0;
            bars_seen  = '0;
            due_results.delete();
        end else begin
            // A result never belongs to the bar taken at the same edge, so results go first.
            if (m_tvalid && m_tready) begin
                check_result($signed(m_tdata[63:0]), m_tdata[79:64], m_tlast);
            end
            if (s_tvalid && s_tready) begin
                advance_bar(s_tdata[23:0], s_tdata[54:24], s_tuser, s_tlast);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_PERIOD: period_q = pwdata[8:0];
                    REG_ALPHA:  alpha_q  = pwdata;
                    REG_WARMUP: warmup_q = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        fail_count   <= mismatches;
        pending      <= due_results.size();
        results_seen <= checked;
    end

endmodule

/* tb/force_index_ema_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for force_index_ema_top: clock, reset, bar stimulus, register writes
// and result back-pressure. Checking is done by force_index_ema_checker; depends on fie_pkg.

module force_index_ema_top_tb;
    import fie_pkg::*;

    localparam int S_TDATA_W      = ((24 + 31 + 7) / 8) * 8;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BARS    = 1500;
    localparam int LONG_SERIES    = 100;
    localparam logic [1:0] REG_NONE = 2'd3;  // address with no register behind it

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // close_price, bar_volume, zero pad
    logic                 s_tlast = 1'b0;
    logic                 s_tuser = 1'b0;  // series_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [79:0]          m_tdata;  // force_value, bar_index
    logic                 m_tlast;

    int          fail_count;
    int          pending;
    int          results_seen;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          rx_hold = 0;
    int          idle_cycles = 0;
    int          bars_sent = 0;
    int          settings_used = 0;
    logic [23:0] close_now = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    force_index_ema_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    force_index_ema_checker #(.S_TDATA_W(S_TDATA_W)) fie_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    // Mostly a random walk, so that forces stay realistic, with jumps to the extremes.
    function automatic logic [23:0] next_close(input logic [23:0] prev);
        int unsigned r;
        int          v;

        r = $urandom_range(0, 99);
        if (r < 15) return 24'($urandom);
        if (r < 20) return 24'h000000;
        if (r < 25) return 24'hFFFFFF;
        v = int'(prev) + int'($urandom_range(0, 2000)) - 1000;
        if (v < 0) v = 0;
        if (v > 16777215) v = 16777215;
        return 24'(v);
    endfunction

    function automatic logic [30:0] next_volume();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 5) return 31'h00000000;
        if (r < 10) return 31'h7FFFFFFF;
        if (r < 35) return 31'($urandom);
        return 31'($urandom_range(0, 1 << 20));
    endfunction

    // The valid stays high from one bar to the next unless a gap is drawn.
    task automatic send_bar(input logic [23:0] close_px, input logic [30:0] volume,
                            input logic start, input logic tail);
        int gap;

        gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, volume, close_px};
        s_tuser  <= start;
        s_tlast  <= tail;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        close_now = close_px;
        bars_sent++;
    endtask

    // Stop sending and wait for every outstanding result, then for bars that give none.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Unused upper data bits are sometimes set, as the registers must ignore them.
    task automatic configure(input logic [8:0] per, input logic [31:0] alp, input logic [7:0] wu);
        logic [31:0] junk;

        settle();
        junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        write_reg(REG_PERIOD, (junk & ~32'h1FF) | 32'(per));
        write_reg(REG_ALPHA, alp);
        write_reg(REG_WARMUP, (junk & ~32'hFF) | 32'(wu));
        settings_used++;
    endtask

    task automatic run_series(input int count, input bit open_with_start, input bit noisy);
        logic [23:0] c;
        bit          start;
        bit          tail;

        for (int i = 0; i < count; i++) begin
            c     = next_close(close_now);
            start = (i == 0) ? open_with_start : (noisy && $urandom_range(0, 99) == 0);
            tail  = (i == count - 1) ? 1'b1 : (noisy && $urandom_range(0, 39) == 0);
            send_bar(c, next_volume(), start, tail);
            if (noisy && $urandom_range(0, 299) == 0) begin
                settle();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("** force_index_ema_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int          phase_no;
        int          r;
        int          span;
        int          len;
        logic [8:0]  per;
        logic [31:0] alp;
        logic [7:0]  wu;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, and a first bar without series_start. Alternating extremes
        // give the largest forces of both signs and zero-volume bars.
        send_bar(24'hFFFFFF, 31'h7FFFFFFF, 1'b0, 1'b0);
        for (int i = 1; i < 15; i++) begin
            send_bar((i % 2) ? 24'h000000 : 24'hFFFFFF,
                     (i % 3 == 0) ? 31'h00000000 : 31'h7FFFFFFF, 1'b0, i == 14);
        end

        // A write to an unused address must change nothing; period zero acts as raw force.
        settle();
        write_reg(REG_NONE, 32'hFFFFFFFF);
        configure(9'd0, $urandom, 8'd0);
        send_bar(24'h000000, 31'h7FFFFFFF, 1'b1, 1'b0);
        send_bar(24'hFFFFFF, 31'h7FFFFFFF, 1'b0, 1'b0);
        send_bar(24'h000000, 31'h7FFFFFFF, 1'b0, 1'b0);
        send_bar(24'h000005, 31'h00000000, 1'b0, 1'b1);

        phase_no = 0;
        while (bars_sent < RANDOM_BARS) begin
            phase_no++;
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle <= ($urandom_range(0, 4) != 0);
            if (phase_no == 3) begin
                // Longest seed and longest silent warm-up together.
                configure(9'd256, 32'd2863311531, 8'd255);
                run_series(520, 1'b1, 1'b0);
            end else if (phase_no == 6) begin
                // A period beyond the maximum is clamped to it.
                configure(9'h1FF, $urandom, 8'd0);
                run_series(270, 1'b1, 1'b0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    per = 9'($urandom_range(0, 1));
                end else if (r < 20) begin
                    per = 9'($urandom_range(9, 40));
                end else begin
                    per = 9'($urandom_range(2, 8));
                end
                span = (per == 0) ? 1 : int'(per);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    alp = 32'h00000000;
                end else if (r < 20) begin
                    alp = 32'hFFFFFFFF;
                end else if (r < 30) begin
                    alp = 32'd2863311531;
                end else if (r < 60) begin
                    alp = 32'((64'd1 << 33) / (span + 1));
                end else begin
                    alp = $urandom;
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    wu = 8'($urandom_range(0, 3));
                end else if (r < 95) begin
                    wu = 8'($urandom_range(4, 20));
                end else begin
                    wu = 8'($urandom_range(21, 255));
                end
                configure(per, alp, wu);
                if ($urandom_range(0, 19) == 0) begin
                    write_reg(REG_NONE, $urandom);
                end
                // Most series are long enough to reach the output; a few stop short.
                // A series opened without series_start carries on under the new settings.
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        len = $urandom_range(1, span + wu);
                    end else begin
                        len = span + wu + $urandom_range(1, 30);
                    end
                    run_series(len, $urandom_range(0, 9) != 0, 1'b1);
                end
            end
        end

        // One unbroken series at full rate on both sides, at period one.
        configure(9'd1, $urandom, 8'd0);
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        run_series(LONG_SERIES, 1'b1, 1'b0);

        settle();
        $display("Run covered %0d bars and %0d results under %0d register settings,",
                 bars_sent, results_seen, settings_used);
        $display("periods zero to beyond the clamp, and a closing series at full rate.");
        if (fail_count == 0 && pending == 0) begin
            $display("** force_index_ema_top: PASSED **");
        end else begin
            if (pending != 0) begin
                $error("%0d expected results never arrived", pending);
            end
            $display("** force_index_ema_top: FAILED **");
        end
        $finish;
    end

endmodule
